FILE: hw/rtl/tcbb_pkg.sv
// shared constants and helper function for the transformed cube bounding box
package tcbb_pkg;

  localparam int ANGLE_W = 26;
  localparam int DATA_W  = 32;

  // quadrant split of the whole-degree part of the angle
  localparam int               U_W            = 19;
  localparam int               QE_W           = 14;
  localparam int               ANGLE_OFFSET   = 131400;
  localparam logic [U_W-1:0]   RECIP_90       = 19'd186413;
  localparam int               RECIP_90_SHIFT = 24;
  localparam int               QUARTER_DEG    = 90;

  // degrees to q30 radians
  localparam logic [31:0] PI_Q30          = 32'd3373259426;
  localparam int          PI_DIV180       = 18740330;
  localparam int          PI_REM180       = 26;
  localparam int          HALF_180        = 90;
  localparam logic [32:0] RECIP_180       = 33'd6108397932;
  localparam int          RECIP_180_SHIFT = 40;
  localparam int          DEG_180         = 180;

  // series evaluation
  localparam logic [31:0] ONE_Q30      = 32'h4000_0000;
  localparam int          HORNER_STEPS = 7;
  localparam int          DIV_SHIFT    = 36;
  localparam int          SC_LAT       = 30;

  function automatic int horner_div(input bit for_sin, input int k);
    horner_div = for_sin ? (2 * k) * (2 * k + 1) : (2 * k - 1) * (2 * k);
  endfunction

endpackage

FILE: hw/rtl/tcbb_sincos.sv
// pipelined sine and cosine of an angle in degrees
module tcbb_sincos #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 adv,
  input  logic signed [tcbb_pkg::ANGLE_W-1:0]  angle,
  output logic signed [FRAC_BITS+1:0]          sin_q,
  output logic signed [FRAC_BITS+1:0]          cos_q
);
  import tcbb_pkg::*;

  localparam int NST = 3 * HORNER_STEPS;

  function automatic logic signed [FRAC_BITS+1:0] to_frac(input logic signed [31:0] v);
    logic [31:0] mag;
    logic [31:0] rnd;
    mag = v[31] ? 32'(-v) : 32'(v);
    rnd = (mag + (32'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
    to_frac = v[31] ? -(FRAC_BITS + 2)'(rnd) : (FRAC_BITS + 2)'(rnd);
  endfunction

  // quadrant split
  logic signed [U_W:0]      hi_ext;
  logic signed [U_W:0]      u_sum;
  logic [U_W-1:0]           s1_u;
  logic [FRAC_BITS-1:0]     s1_lo;
  logic [2*U_W-1:0]         s2_prod;
  logic [QE_W-1:0]          s2_qe;
  logic [U_W-1:0]           s2_u;
  logic [FRAC_BITS-1:0]     s2_lo;
  logic [U_W-1:0]           rem_raw;
  logic [1:0]               s3_q;
  logic [6:0]               s3_r1;
  logic [FRAC_BITS-1:0]     s3_lo;

  assign hi_ext  = (U_W + 1)'($signed(angle[ANGLE_W-1:FRAC_BITS]));
  assign u_sum   = hi_ext + (U_W + 1)'(ANGLE_OFFSET);
  assign s2_prod = (2 * U_W)'(s1_u) * (2 * U_W)'(RECIP_90);
  assign rem_raw = s2_u - U_W'(U_W'(s2_qe) * U_W'(QUARTER_DEG));

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_u  <= u_sum[U_W-1:0];
      s1_lo <= angle[FRAC_BITS-1:0];
      s2_qe <= s2_prod[2*U_W-1:RECIP_90_SHIFT];
      s2_u  <= s1_u;
      s2_lo <= s1_lo;
      if (rem_raw >= U_W'(QUARTER_DEG)) begin
        s3_r1 <= 7'(rem_raw - U_W'(QUARTER_DEG));
        s3_q  <= s2_qe[1:0] + 2'd1;
      end else begin
        s3_r1 <= 7'(rem_raw);
        s3_q  <= s2_qe[1:0];
      end
      s3_lo <= s2_lo;
    end
  end

  // remainder to q30 radians
  logic [FRAC_BITS+31:0] lo_pi;
  logic [32:0]           v_next;
  logic [32:0]           s4_v;
  logic [30:0]           s4_base;
  logic [1:0]            s4_q;
  logic [65:0]           s5_prod;
  logic [25:0]           s5_qd;
  logic [32:0]           s5_v;
  logic [30:0]           s5_base;
  logic [1:0]            s5_q;
  logic [32:0]           chk180;
  logic [25:0]           qd_fix;
  logic [30:0]           s6_x;
  logic [1:0]            s6_q;
  logic [61:0]           xx;

  assign lo_pi   = (FRAC_BITS + 32)'(s3_lo) * (FRAC_BITS + 32)'(PI_Q30);
  assign v_next  = 33'(lo_pi[FRAC_BITS+31:FRAC_BITS]) + 33'(s3_r1) * 33'(PI_REM180)
                   + 33'(HALF_180);
  assign s5_prod = 66'(s4_v) * 66'(RECIP_180);
  assign chk180  = s5_v - 33'(s5_qd) * 33'(DEG_180);
  assign qd_fix  = (chk180 >= 33'(DEG_180)) ? s5_qd + 26'd1 : s5_qd;
  assign xx      = 62'(s6_x) * 62'(s6_x);

  // horner pipeline carriers
  logic [31:0]        h_x2 [NST+1];
  logic [30:0]        h_x  [NST+1];
  logic [1:0]         h_q  [NST+1];
  logic signed [31:0] st   [HORNER_STEPS+1];
  logic signed [31:0] ct   [HORNER_STEPS+1];

  assign st[0] = $signed(ONE_Q30);
  assign ct[0] = $signed(ONE_Q30);

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_v    <= v_next;
      s4_base <= 31'(s3_r1) * 31'(PI_DIV180);
      s4_q    <= s3_q;
      s5_qd   <= s5_prod[65:RECIP_180_SHIFT];
      s5_v    <= s4_v;
      s5_base <= s4_base;
      s5_q    <= s4_q;
      s6_x    <= s5_base + 31'(qd_fix);
      s6_q    <= s5_q;
      h_x2[0] <= xx[61:30];
      h_x[0]  <= s6_x;
      h_q[0]  <= s6_q;
      for (int j = 1; j <= NST; j++) begin
        h_x2[j] <= h_x2[j-1];
        h_x[j]  <= h_x[j-1];
        h_q[j]  <= h_q[j-1];
      end
    end
  end

  for (genvar g = 0; g < HORNER_STEPS; g++) begin : g_step
    localparam int SD = horner_div(1'b1, HORNER_STEPS - g);
    localparam int CD = horner_div(1'b0, HORNER_STEPS - g);
    localparam logic [35:0] SRD = 36'((64'd1 << DIV_SHIFT) / 64'(SD));
    localparam logic [35:0] CRD = 36'((64'd1 << DIV_SHIFT) / 64'(CD));

    logic [63:0] sp;
    logic [63:0] cp;
    logic [31:0] sy_a;
    logic [31:0] cy_a;
    logic [67:0] sm;
    logic [67:0] cm;
    logic [31:0] sy_b;
    logic [31:0] cy_b;
    logic [31:0] sq_b;
    logic [31:0] cq_b;
    logic [31:0] schk;
    logic [31:0] cchk;
    logic [31:0] sq_fix;
    logic [31:0] cq_fix;
    logic signed [31:0] st_r;
    logic signed [31:0] ct_r;

    assign sp     = 64'(h_x2[3*g]) * 64'(st[g][30:0]);
    assign cp     = 64'(h_x2[3*g]) * 64'(ct[g][30:0]);
    assign sm     = 68'(sy_a) * 68'(SRD);
    assign cm     = 68'(cy_a) * 68'(CRD);
    assign schk   = sy_b - sq_b * 32'(SD);
    assign cchk   = cy_b - cq_b * 32'(CD);
    assign sq_fix = (schk >= 32'(SD)) ? sq_b + 32'd1 : sq_b;
    assign cq_fix = (cchk >= 32'(CD)) ? cq_b + 32'd1 : cq_b;

    always_ff @(posedge clk) begin
      if (adv) begin
        sy_a <= sp[61:30];
        cy_a <= cp[61:30];
        sq_b <= sm[67:DIV_SHIFT];
        cq_b <= cm[67:DIV_SHIFT];
        sy_b <= sy_a;
        cy_b <= cy_a;
        st_r <= $signed(ONE_Q30 - sq_fix);
        ct_r <= $signed(ONE_Q30 - cq_fix);
      end
    end

    assign st[g+1] = st_r;
    assign ct[g+1] = ct_r;
  end

  // sine product, then quadrant fold and rounding
  logic [61:0]        sxp;
  logic signed [31:0] f_s;
  logic signed [31:0] f_c;
  logic [1:0]         f_q;
  logic signed [31:0] sn;
  logic signed [31:0] cs;

  assign sxp = 62'(h_x[NST]) * 62'(st[HORNER_STEPS][30:0]);

  always_comb begin
    unique case (f_q)
      2'd0: begin
        sn = f_s;
        cs = f_c;
      end
      2'd1: begin
        sn = f_c;
        cs = -f_s;
      end
      2'd2: begin
        sn = -f_s;
        cs = -f_c;
      end
      2'd3: begin
        sn = -f_c;
        cs = f_s;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_s   <= $signed(sxp[61:30]);
      f_c   <= ct[HORNER_STEPS];
      f_q   <= h_q[NST];
      sin_q <= to_frac(sn);
      cos_q <= to_frac(cs);
    end
  end

endmodule

FILE: hw/rtl/transformed_cube_bounding_box_top.sv
// top level: axis-aligned box of a placed, rotated and scaled unit cube
//
// Input channel in_valid/in_stall carries one placement: position, rotation
// angles in degrees about x, y and z, and per-axis scale, all signed fixed
// point with FRAC_BITS fraction bits. Output channel out_valid/out_stall
// returns the least and greatest corner coordinate on each axis, saturated
// to 32 bits. A transfer happens when valid is high and stall is low.
//
// The pipeline takes one placement per cycle while it is not stalled. The
// sine/cosine units (quadrant split, degree-to-radian multiply, seven
// Horner steps of three stages each) come first, then the matrix products, the
// scale products, the extent sums and the final shift with saturation.
//
// While out_stall holds a finished result, the whole pipeline freezes and
// in_stall goes high; no stage moves until out_stall drops.
// Reset clears the stage valid bits only; no result is pending afterwards.
module transformed_cube_bounding_box_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [tcbb_pkg::DATA_W-1:0]   pos_x,
  input  logic signed [tcbb_pkg::DATA_W-1:0]   pos_y,
  input  logic signed [tcbb_pkg::DATA_W-1:0]   pos_z,
  input  logic signed [tcbb_pkg::ANGLE_W-1:0]  angle_x,
  input  logic signed [tcbb_pkg::ANGLE_W-1:0]  angle_y,
  input  logic signed [tcbb_pkg::ANGLE_W-1:0]  angle_z,
  input  logic signed [tcbb_pkg::DATA_W-1:0]   scale_x,
  input  logic signed [tcbb_pkg::DATA_W-1:0]   scale_y,
  input  logic signed [tcbb_pkg::DATA_W-1:0]   scale_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [tcbb_pkg::DATA_W-1:0]   box_min_x,
  output logic signed [tcbb_pkg::DATA_W-1:0]   box_min_y,
  output logic signed [tcbb_pkg::DATA_W-1:0]   box_min_z,
  output logic signed [tcbb_pkg::DATA_W-1:0]   box_max_x,
  output logic signed [tcbb_pkg::DATA_W-1:0]   box_max_y,
  output logic signed [tcbb_pkg::DATA_W-1:0]   box_max_z
);
  import tcbb_pkg::*;

  localparam int LAT  = SC_LAT + 5;
  localparam int SW   = FRAC_BITS + 2;
  localparam int RW   = SW + 1;
  localparam int EW   = RW + DATA_W;
  localparam int SUMW = EW + 4;

  localparam logic signed [2*SW-1:0] MQ_HALF  = (2 * SW)'(1) << (FRAC_BITS - 1);
  localparam logic signed [SUMW-1:0] BOX_HALF = SUMW'(1) << FRAC_BITS;
  localparam logic signed [SUMW-1:0] SAT_HI   = SUMW'(32'h7fff_ffff);
  localparam logic signed [SUMW-1:0] SAT_LO   = -SAT_HI - SUMW'(1);

  function automatic logic signed [SW-1:0] mulq(input logic signed [SW-1:0] a,
                                                input logic signed [SW-1:0] b);
    logic signed [2*SW-1:0] p;
    p = (2 * SW)'(a) * (2 * SW)'(b);
    p = (p + MQ_HALF) >>> FRAC_BITS;
    mulq = SW'(p);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat(input logic signed [SUMW-1:0] v);
    logic signed [SUMW-1:0] sh;
    sh = v >>> (FRAC_BITS + 1);
    if (sh > SAT_HI) begin
      sat = SAT_HI[DATA_W-1:0];
    end else if (sh < SAT_LO) begin
      sat = SAT_LO[DATA_W-1:0];
    end else begin
      sat = sh[DATA_W-1:0];
    end
  endfunction

  logic           adv;
  logic [LAT-1:0] vld;

  assign out_valid = vld[LAT-1];
  assign in_stall  = vld[LAT-1] & out_stall;
  assign adv       = ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // sine and cosine
  logic signed [SW-1:0] sx, cx, sy, cy, sz, cz;

  tcbb_sincos #(.FRAC_BITS(FRAC_BITS)) u_sc_x (
    .clk(clk), .adv(adv), .angle(angle_x), .sin_q(sx), .cos_q(cx)
  );
  tcbb_sincos #(.FRAC_BITS(FRAC_BITS)) u_sc_y (
    .clk(clk), .adv(adv), .angle(angle_y), .sin_q(sy), .cos_q(cy)
  );
  tcbb_sincos #(.FRAC_BITS(FRAC_BITS)) u_sc_z (
    .clk(clk), .adv(adv), .angle(angle_z), .sin_q(sz), .cos_q(cz)
  );

  // position and scale ride alongside
  logic signed [DATA_W-1:0] pos_d [SC_LAT][3];
  logic signed [DATA_W-1:0] scl_d [SC_LAT][3];

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_d[0][0] <= pos_x;
      pos_d[0][1] <= pos_y;
      pos_d[0][2] <= pos_z;
      scl_d[0][0] <= scale_x;
      scl_d[0][1] <= scale_y;
      scl_d[0][2] <= scale_z;
      for (int i = 1; i < SC_LAT; i++) begin
        pos_d[i] <= pos_d[i-1];
        scl_d[i] <= scl_d[i-1];
      end
    end
  end

  // first-level matrix products
  logic signed [SW-1:0] m1_cycz, m1_cysz, m1_cxsz, m1_cxcz, m1_sxcy;
  logic signed [SW-1:0] m1_cxcy, m1_sxsy, m1_cxsy, m1_sxsz, m1_sxcz;
  logic signed [SW-1:0] m1_sy, m1_sz, m1_cz;
  logic signed [DATA_W-1:0] m1_pos [3];
  logic signed [DATA_W-1:0] m1_scl [3];

  // rotation matrix
  logic signed [RW-1:0] r_next [9];
  logic signed [RW-1:0] m2_r   [9];
  logic signed [DATA_W-1:0] m2_pos [3];
  logic signed [DATA_W-1:0] m2_scl [3];

  always_comb begin
    r_next[0] = RW'(m1_cycz);
    r_next[1] = -RW'(m1_cysz);
    r_next[2] = RW'(m1_sy);
    r_next[3] = RW'(m1_cxsz) + RW'(mulq(m1_sxsy, m1_cz));
    r_next[4] = RW'(m1_cxcz) - RW'(mulq(m1_sxsy, m1_sz));
    r_next[5] = -RW'(m1_sxcy);
    r_next[6] = RW'(m1_sxsz) - RW'(mulq(m1_cxsy, m1_cz));
    r_next[7] = RW'(m1_sxcz) + RW'(mulq(m1_cxsy, m1_sz));
    r_next[8] = RW'(m1_cxcy);
  end

  // scaled extents
  logic signed [EW-1:0] e_prod [9];
  logic [EW-1:0]        m3_ae  [9];
  logic signed [DATA_W-1:0] m3_pos [3];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      e_prod[k] = EW'(m2_r[k]) * EW'(m2_scl[k % 3]);
    end
  end

  // box sums
  logic [EW+1:0]          ext      [3];
  logic signed [SUMW-1:0] centre   [3];
  logic signed [SUMW-1:0] lo_next  [3];
  logic signed [SUMW-1:0] hi_next  [3];
  logic signed [SUMW-1:0] m4_lo    [3];
  logic signed [SUMW-1:0] m4_hi    [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ext[i]     = (EW + 2)'(m3_ae[3*i]) + (EW + 2)'(m3_ae[3*i+1])
                   + (EW + 2)'(m3_ae[3*i+2]);
      centre[i]  = SUMW'(m3_pos[i]) <<< (FRAC_BITS + 1);
      lo_next[i] = centre[i] - $signed(SUMW'(ext[i])) + BOX_HALF;
      hi_next[i] = centre[i] + $signed(SUMW'(ext[i])) + BOX_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_cycz <= mulq(cy, cz);
      m1_cysz <= mulq(cy, sz);
      m1_cxsz <= mulq(cx, sz);
      m1_cxcz <= mulq(cx, cz);
      m1_sxcy <= mulq(sx, cy);
      m1_cxcy <= mulq(cx, cy);
      m1_sxsy <= mulq(sx, sy);
      m1_cxsy <= mulq(cx, sy);
      m1_sxsz <= mulq(sx, sz);
      m1_sxcz <= mulq(sx, cz);
      m1_sy   <= sy;
      m1_sz   <= sz;
      m1_cz   <= cz;
      m1_pos  <= pos_d[SC_LAT-1];
      m1_scl  <= scl_d[SC_LAT-1];
      m2_r    <= r_next;
      m2_pos  <= m1_pos;
      m2_scl  <= m1_scl;
      for (int k = 0; k < 9; k++) begin
        m3_ae[k] <= e_prod[k][EW-1] ? EW'(-e_prod[k]) : EW'(e_prod[k]);
      end
      m3_pos    <= m2_pos;
      m4_lo     <= lo_next;
      m4_hi     <= hi_next;
      box_min_x <= sat(m4_lo[0]);
      box_min_y <= sat(m4_lo[1]);
      box_min_z <= sat(m4_lo[2]);
      box_max_x <= sat(m4_hi[0]);
      box_max_y <= sat(m4_hi[1]);
      box_max_z <= sat(m4_hi[2]);
    end
  end

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (box_min_x <= box_max_x) && (box_min_y <= box_max_y)
                  && (box_min_z <= box_max_z))
    else $error("box min above max");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result pending after reset");

  a_empty_accepts: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule
